@@ design/saf_pkg.sv @@
// saf_pkg: shared types and constants of the sonar altitude filter
// used by saf_ring and sonar_altitude_filter_core; no dependencies

package saf_pkg;

   // fixed field widths
   localparam int SAMPLE_W = 11;
   localparam int POS_W    = 15;
   localparam int VEL_W    = 24;
   localparam int GAIN_W   = 8;
   localparam int CSR_IDX_W = 2;

   // readings below this are too low
   localparam logic [SAMPLE_W-1:0] LOW_LIMIT_CM = 11'd3;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_JUMP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN     = 2'd2;

   // register reset values
   localparam logic [SAMPLE_W-1:0] MAX_JUMP_RST = 11'd50;
   localparam logic [SAMPLE_W-1:0] RANGE_RST    = 11'd700;
   localparam logic [GAIN_W-1:0]   GAIN_RST     = 8'd20;

   // classification of a limited reading as it travels down the pipeline
   typedef enum logic [1:0] {
      KIND_LOW,
      KIND_HIGH,
      KIND_FILL,
      KIND_MEAN
   } kind_type;

   // write request into the sample ring
   typedef struct packed {
      logic                en;
      logic [SAMPLE_W-1:0] sample;
   } ring_wr_type;

endpackage

@@ design/saf_ring.sv @@
// saf_ring: ring of recent samples in a synchronous memory with prefetch of
// the slot that the next write replaces; depends on saf_pkg

module saf_ring #(
   parameter int AVG_DEPTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  saf_pkg::ring_wr_type          wr,
   output logic [saf_pkg::SAMPLE_W-1:0]  old_sample
);

   localparam int IDX_W = $clog2(AVG_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVG_DEPTH - 1);

   logic [saf_pkg::SAMPLE_W-1:0] mem [AVG_DEPTH];
   logic [saf_pkg::SAMPLE_W-1:0] rd_ff;
   logic [IDX_W-1:0]             wr_idx_ff;
   logic [IDX_W-1:0]             wr_idx_in;
   logic [AVG_DEPTH-1:0]         slot_vld_ff;
   logic [AVG_DEPTH-1:0]         slot_vld_in;

   // write pointer advances on every write and wraps at the ring depth
   always_comb begin
      wr_idx_in   = wr_idx_ff;
      slot_vld_in = slot_vld_ff;
      if (wr.en) begin
         wr_idx_in = (wr_idx_ff == IDX_LAST) ? '0 : wr_idx_ff + 1'b1;
         slot_vld_in[wr_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff   <= '0;
         slot_vld_ff <= '0;
      end else begin
         wr_idx_ff   <= wr_idx_in;
         slot_vld_ff <= slot_vld_in;
      end
   end

   // memory: write at the current slot, prefetch the slot the next write hits
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_idx_ff] <= wr.sample;
      end
      rd_ff <= mem[wr_idx_in];
   end

   // a slot never written since reset reads as zero
   assign old_sample = slot_vld_ff[wr_idx_ff] ? rd_ff : '0;

endmodule

@@ design/sonar_altitude_filter_core.sv @@
// sonar_altitude_filter_core: slew limited moving average of sonar altitude with velocity
// path: a result is registered in stages 1, 2 and 3 and the output register before rsp_ shows it
// throughput: one reading per cycle while rsp_stall is low; sum and ring slot update per reading
// stalls: req_stall rises only once all four pipeline stages hold a result behind rsp_stall
// reset: synchronous, registers take their reset values and every ring slot reads as zero
// depends on saf_pkg and saf_ring

module sonar_altitude_filter_core #(
   parameter int AVG_DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // reading channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [saf_pkg::SAMPLE_W-1:0]     req_altitude_cm,
   input  logic                             req_read_failed,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_too_low,
   output logic                             rsp_too_high,
   output logic [saf_pkg::POS_W-1:0]        rsp_position_q4,
   output logic                             rsp_mean_ready,
   output logic signed [saf_pkg::VEL_W-1:0] rsp_velocity_q4,
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [saf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [saf_pkg::SAMPLE_W-1:0]     csr_wdata
);

   localparam int IDX_W  = $clog2(AVG_DEPTH);
   localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
   localparam int SUM_W  = saf_pkg::SAMPLE_W + IDX_W;
   localparam int NUM_W  = SUM_W + 4;
   localparam int SHIFT  = NUM_W + IDX_W;
   localparam int RCP_W  = NUM_W + 2;
   localparam int PROD_W = NUM_W + RCP_W;
   localparam logic [RCP_W-1:0] RECIP =
      RCP_W'(((64'd1 << SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
   localparam logic [NUM_W-1:0] ROUND_HALF = NUM_W'(AVG_DEPTH / 2);
   localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(AVG_DEPTH);
   localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(AVG_DEPTH - 1);

   // configuration registers
   logic [saf_pkg::SAMPLE_W-1:0] jump_ff;
   logic [saf_pkg::SAMPLE_W-1:0] range_ff;
   logic [saf_pkg::GAIN_W-1:0]   gain_ff;

   // filter state
   logic [saf_pkg::SAMPLE_W-1:0] prev_ff;
   logic [SUM_W-1:0]             sum_ff;
   logic [SUM_W-1:0]             sum_in;
   logic [CNT_W-1:0]             count_ff;
   logic                         mean_vld_ff;
   logic [saf_pkg::POS_W-1:0]    last_mean_ff;
   logic [saf_pkg::POS_W-1:0]    held_ff;

   // pipeline stages
   logic                         s1_vld_ff;
   saf_pkg::kind_type            s1_kind_ff;
   logic                         s1_had_mean_ff;
   logic [NUM_W-1:0]             s1_num_ff;
   logic                         s2_vld_ff;
   saf_pkg::kind_type            s2_kind_ff;
   logic                         s2_had_mean_ff;
   logic [PROD_W-1:0]            s2_prod_ff;
   logic [PROD_W-1:0]            s2_prod_in;
   logic                         s3_vld_ff;
   logic                         s3_low_ff;
   logic                         s3_high_ff;
   logic                         s3_ready_ff;
   logic                         s3_vel_en_ff;
   logic [saf_pkg::POS_W-1:0]    s3_pos_ff;
   logic [saf_pkg::POS_W-1:0]    s3_pos_in;
   logic signed [saf_pkg::POS_W:0] s3_diff_ff;
   logic signed [saf_pkg::POS_W:0] s3_diff_in;
   logic                         rsp_valid_ff;
   logic signed [saf_pkg::VEL_W:0] vel_full;

   logic                         s1_en;
   logic                         s2_en;
   logic                         s3_en;
   logic                         out_en;
   logic                         accept;
   logic                         take;

   logic [saf_pkg::SAMPLE_W:0]   hi_sum;
   logic [saf_pkg::SAMPLE_W-1:0] lim;
   logic                         is_low;
   logic                         is_high;
   logic                         mean_evt;
   saf_pkg::kind_type            kind;
   logic [saf_pkg::SAMPLE_W-1:0] old_sample;
   saf_pkg::ring_wr_type         ring_wr;
   logic [saf_pkg::POS_W-1:0]    mean;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         jump_ff  <= saf_pkg::MAX_JUMP_RST;
         range_ff <= saf_pkg::RANGE_RST;
         gain_ff  <= saf_pkg::GAIN_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            saf_pkg::CSR_MAX_JUMP: jump_ff  <= csr_wdata;
            saf_pkg::CSR_RANGE:    range_ff <= csr_wdata;
            saf_pkg::CSR_GAIN:     gain_ff  <= csr_wdata[saf_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // stage enables: a stage moves when empty or when the next one moves
   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign s3_en     = !s3_vld_ff || out_en;
   assign s2_en     = !s2_vld_ff || s3_en;
   assign s1_en     = !s1_vld_ff || s2_en;
   assign req_stall = !s1_en;
   assign accept    = req_valid && s1_en;
   assign take      = accept && !req_read_failed;

   // slew limit against the previous limited reading
   always_comb begin
      hi_sum = {1'b0, prev_ff} + {1'b0, jump_ff};
      if ({1'b0, req_altitude_cm} > hi_sum) begin
         lim = hi_sum[saf_pkg::SAMPLE_W-1:0];
      end else if (prev_ff >= jump_ff && req_altitude_cm < prev_ff - jump_ff) begin
         lim = prev_ff - jump_ff;
      end else begin
         lim = req_altitude_cm;
      end
   end

   // classify the limited reading
   always_comb begin
      is_low   = lim < saf_pkg::LOW_LIMIT_CM;
      is_high  = !is_low && lim >= range_ff;
      mean_evt = !is_low && !is_high && count_ff >= CNT_LAST;
      if (is_low) begin
         kind = saf_pkg::KIND_LOW;
      end else if (is_high) begin
         kind = saf_pkg::KIND_HIGH;
      end else if (mean_evt) begin
         kind = saf_pkg::KIND_MEAN;
      end else begin
         kind = saf_pkg::KIND_FILL;
      end
   end

   // ring write and running sum
   assign ring_wr.en     = take && !is_low && !is_high;
   assign ring_wr.sample = lim;
   assign sum_in = sum_ff - SUM_W'(old_sample) + SUM_W'(lim);

   saf_ring #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .wr         (ring_wr),
      .old_sample (old_sample)
   );

   // filter state update on each reading transfer that is not a failed read
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         sum_ff      <= '0;
         count_ff    <= '0;
         mean_vld_ff <= 1'b0;
      end else if (take) begin
         prev_ff <= lim;
         if (is_low || is_high) begin
            count_ff    <= '0;
            mean_vld_ff <= 1'b0;
         end else begin
            sum_ff <= sum_in;
            if (mean_evt) begin
               count_ff    <= CNT_FULL;
               mean_vld_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + 1'b1;
            end
         end
      end
   end

   // stage 1: classification and rounded numerator of the mean
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_en) begin
         s1_vld_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_kind_ff     <= kind;
         s1_had_mean_ff <= mean_vld_ff;
         s1_num_ff      <= {sum_in, 4'b0000} + ROUND_HALF;
      end
   end

   // stage 2: division by the depth as multiply by its reciprocal
   assign s2_prod_in = PROD_W'(s1_num_ff) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (s2_en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_kind_ff     <= s1_kind_ff;
         s2_had_mean_ff <= s1_had_mean_ff;
         s2_prod_ff     <= s2_prod_in;
      end
   end

   // stage 3: position select, mean difference, held and last mean update
   assign mean       = s2_prod_ff[SHIFT +: saf_pkg::POS_W];
   assign s3_diff_in = $signed({1'b0, mean}) - $signed({1'b0, last_mean_ff});

   always_comb begin
      case (s2_kind_ff)
         saf_pkg::KIND_LOW:  s3_pos_in = '0;
         saf_pkg::KIND_HIGH: s3_pos_in = {range_ff, 4'b0000};
         saf_pkg::KIND_MEAN: s3_pos_in = mean;
         default:            s3_pos_in = held_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff    <= 1'b0;
         held_ff      <= '0;
         last_mean_ff <= '0;
      end else if (s3_en) begin
         s3_vld_ff <= s2_vld_ff;
         if (s2_vld_ff) begin
            held_ff <= s3_pos_in;
            if (s2_kind_ff == saf_pkg::KIND_MEAN) begin
               last_mean_ff <= mean;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_low_ff    <= s2_kind_ff == saf_pkg::KIND_LOW;
         s3_high_ff   <= s2_kind_ff == saf_pkg::KIND_HIGH;
         s3_ready_ff  <= s2_kind_ff == saf_pkg::KIND_MEAN;
         s3_vel_en_ff <= s2_kind_ff == saf_pkg::KIND_MEAN && s2_had_mean_ff;
         s3_pos_ff    <= s3_pos_in;
         s3_diff_ff   <= s3_diff_in;
      end
   end

   // output register: velocity as gain times mean difference, zero unless a mean follows an earlier mean
   assign vel_full = (saf_pkg::VEL_W+1)'($signed({1'b0, gain_ff}))
                   * (saf_pkg::VEL_W+1)'(s3_diff_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_too_low     <= s3_low_ff;
         rsp_too_high    <= s3_high_ff;
         rsp_mean_ready  <= s3_ready_ff;
         rsp_position_q4 <= s3_pos_ff;
         rsp_velocity_q4 <= s3_vel_en_ff ? vel_full[saf_pkg::VEL_W-1:0] : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // valid count saturates at the ring depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("valid count above ring depth");

   // a failed read leaves the limiter state untouched
   a_failed_ignored: assert property (@(posedge clock) disable iff (reset)
      (accept && req_read_failed) |=> $stable(prev_ff) && $stable(count_ff))
      else $error("failed read changed filter state");

   // a too low result always reports position zero and no mean
   a_low_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_low) |-> (rsp_position_q4 == '0 && !rsp_mean_ready))
      else $error("too low result carries a position or mean");

   // velocity is zero unless a new mean was produced
   a_vel_needs_mean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_mean_ready) |-> rsp_velocity_q4 == '0)
      else $error("velocity without a new mean");

   // a ring write only happens for a reading inside the usable range
   a_ring_write_range: assert property (@(posedge clock) disable iff (reset)
      ring_wr.en |-> (ring_wr.sample >= saf_pkg::LOW_LIMIT_CM && ring_wr.sample < range_ff))
      else $error("out of range reading written to the ring");
`endif

endmodule
